FILE: rtl/integer_alu_with_divide_macros.svh
// Assertion macros used by the block's top-level module.
`ifndef INTEGER_ALU_WITH_DIVIDE_MACROS_SVH
`define INTEGER_ALU_WITH_DIVIDE_MACROS_SVH
// Asserts that a condition implies a consequence in the same cycle.
`define IAD_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
// Asserts that a condition implies a consequence in the next cycle.
`define IAD_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/iad_pkg.sv
// Package with the operation codes, status codes and cell types of the ALU.
package iad_pkg;
  localparam int DW = 32;
  localparam int OPW = 5;
  localparam int NCELL = DW;

  typedef enum logic [4:0] {
    OP_ODD = 5'd0, OP_EVEN = 5'd1, OP_ZERO = 5'd2, OP_POS = 5'd3, OP_NEG = 5'd4,
    OP_NEGATE = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_MUL = 5'd8, OP_EXDIV = 5'd9,
    OP_LT = 5'd10, OP_ABS = 5'd11, OP_QUOT = 5'd12, OP_SHIFT = 5'd13, OP_NOT = 5'd14,
    OP_AND = 5'd15, OP_OR = 5'd16, OP_XOR = 5'd17, OP_MOD = 5'd18, OP_REM = 5'd19,
    OP_TDIV = 5'd20
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_INEXACT = 2'd2
  } status_t;

  typedef struct packed {
    logic          vld;
    logic [OPW-1:0] op;
    logic          is_div;
    logic          neg_a;
    logic          neg_b;
    logic [DW-1:0] b;
    logic [DW-1:0] mb;
    logic [DW-1:0] rm;
    logic [DW-1:0] qm;
    logic [DW-1:0] res;
    logic          truth;
    logic [1:0]    status;
  } cell_t;
endpackage

FILE: rtl/iad_cell.sv
// One cell of the restoring divider chain: produces one quotient bit per stage.
module iad_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  iad_pkg::cell_t d_in,
  output iad_pkg::cell_t d_out
);
  iad_pkg::cell_t cur_r, cur_nxt;
  logic [iad_pkg::DW:0] trial;
  logic [iad_pkg::DW:0] shifted;

  always_comb begin
    cur_nxt = d_in;
    shifted = {d_in.rm, d_in.qm[iad_pkg::DW-1]};
    trial = shifted - {1'b0, d_in.mb};
    cur_nxt.qm = {d_in.qm[iad_pkg::DW-2:0], 1'b0};
    if (d_in.is_div) begin
      if (!trial[iad_pkg::DW]) begin
        cur_nxt.rm = trial[iad_pkg::DW-1:0];
        cur_nxt.qm[0] = 1'b1;
      end else begin
        cur_nxt.rm = shifted[iad_pkg::DW-1:0];
      end
    end else begin
      cur_nxt.rm = d_in.rm;
      cur_nxt.qm = d_in.qm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.vld <= 1'b0;
    end else if (adv) begin
      cur_r.vld <= cur_nxt.vld;
    end
    if (adv) begin
      cur_r.op <= cur_nxt.op;
      cur_r.is_div <= cur_nxt.is_div;
      cur_r.neg_a <= cur_nxt.neg_a;
      cur_r.neg_b <= cur_nxt.neg_b;
      cur_r.b <= cur_nxt.b;
      cur_r.mb <= cur_nxt.mb;
      cur_r.rm <= cur_nxt.rm;
      cur_r.qm <= cur_nxt.qm;
      cur_r.res <= cur_nxt.res;
      cur_r.truth <= cur_nxt.truth;
      cur_r.status <= cur_nxt.status;
    end
  end

  assign d_out = cur_r;
endmodule

FILE: rtl/iad_front.sv
// Input stage: decodes the operation, computes the non-divide results.
module iad_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    vld,
  input  logic [iad_pkg::OPW-1:0] op,
  input  logic [iad_pkg::DW-1:0]  a,
  input  logic [iad_pkg::DW-1:0]  b,
  output iad_pkg::cell_t          d_out
);
  iad_pkg::cell_t st_r, st_nxt;
  logic neg_a, neg_b, isd;
  logic [iad_pkg::DW-1:0] ma, mb, res, nb, prod, sra;
  logic signed [iad_pkg::DW-1:0] sa;
  logic tr;

  always_comb begin
    neg_a = a[iad_pkg::DW-1];
    neg_b = b[iad_pkg::DW-1];
    ma = neg_a ? (~a + 1'b1) : a;
    mb = neg_b ? (~b + 1'b1) : b;
    nb = ~b + 1'b1;
    sa = a;
    sra = sa >>> nb[5:0];
    prod = a * b;
    res = '0;
    tr = 1'b0;
    isd = 1'b0;
    case (op)
      iad_pkg::OP_ODD: tr = a[0];
      iad_pkg::OP_EVEN: tr = ~a[0];
      iad_pkg::OP_ZERO: tr = (a == '0);
      iad_pkg::OP_POS: tr = !neg_a && (a != '0);
      iad_pkg::OP_NEG: tr = neg_a;
      iad_pkg::OP_NEGATE: res = ~a + 1'b1;
      iad_pkg::OP_ADD: res = a + b;
      iad_pkg::OP_SUB: res = a - b;
      iad_pkg::OP_MUL: res = prod;
      iad_pkg::OP_LT: tr = $signed(a) < $signed(b);
      iad_pkg::OP_ABS: res = ma;
      iad_pkg::OP_SHIFT: begin
        if (!neg_b && b != '0) begin
          res = (b >= iad_pkg::DW) ? '0 : (a << b[5:0]);
        end else begin
          res = (nb >= iad_pkg::DW || neg_b && nb == '0) ?
                {iad_pkg::DW{neg_a}} : sra;
        end
      end
      iad_pkg::OP_NOT: res = ~a;
      iad_pkg::OP_AND: res = a & b;
      iad_pkg::OP_OR: res = a | b;
      iad_pkg::OP_XOR: res = a ^ b;
      iad_pkg::OP_EXDIV, iad_pkg::OP_QUOT, iad_pkg::OP_MOD, iad_pkg::OP_REM,
      iad_pkg::OP_TDIV: isd = 1'b1;
      default: res = '0;
    endcase
    st_nxt.vld = vld;
    st_nxt.op = op;
    st_nxt.is_div = isd && (b != '0);
    st_nxt.neg_a = neg_a;
    st_nxt.neg_b = neg_b;
    st_nxt.b = b;
    st_nxt.mb = mb;
    st_nxt.rm = '0;
    st_nxt.qm = ma;
    st_nxt.res = res;
    st_nxt.truth = tr;
    st_nxt.status = (isd && b == '0) ? iad_pkg::ST_DIV_ZERO : iad_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (adv) begin
      st_r.vld <= st_nxt.vld;
    end
    if (adv) begin
      st_r.op <= st_nxt.op;
      st_r.is_div <= st_nxt.is_div;
      st_r.neg_a <= st_nxt.neg_a;
      st_r.neg_b <= st_nxt.neg_b;
      st_r.b <= st_nxt.b;
      st_r.mb <= st_nxt.mb;
      st_r.rm <= st_nxt.rm;
      st_r.qm <= st_nxt.qm;
      st_r.res <= st_nxt.res;
      st_r.truth <= st_nxt.truth;
      st_r.status <= st_nxt.status;
    end
  end

  assign d_out = st_r;
endmodule

FILE: rtl/iad_back.sv
// Output stage: applies signs, selects the divide result and holds the word.
module iad_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  iad_pkg::cell_t         d_in,
  output logic                   vld,
  output logic [iad_pkg::DW-1:0] res,
  output logic [iad_pkg::DW-1:0] rem,
  output logic                   truth,
  output logic [1:0]             status
);
  logic vld_r;
  logic [iad_pkg::DW-1:0] res_r, res_nxt, rem_r, rem_nxt, q, r, rb;
  logic tr_r, tr_nxt;
  logic [1:0] st_r, st_nxt;

  always_comb begin
    q = (d_in.neg_a != d_in.neg_b) ? (~d_in.qm + 1'b1) : d_in.qm;
    r = d_in.neg_a ? (~d_in.rm + 1'b1) : d_in.rm;
    rb = r + d_in.b;
    res_nxt = d_in.res;
    rem_nxt = '0;
    tr_nxt = d_in.truth;
    st_nxt = d_in.status;
    if (d_in.is_div) begin
      case (d_in.op)
        iad_pkg::OP_EXDIV: begin
          res_nxt = q;
          if (r != '0) st_nxt = iad_pkg::ST_INEXACT;
        end
        iad_pkg::OP_QUOT: res_nxt = q;
        iad_pkg::OP_MOD: res_nxt = (r != '0 && d_in.neg_a != d_in.neg_b) ? rb : r;
        iad_pkg::OP_REM: res_nxt = r;
        iad_pkg::OP_TDIV: begin
          res_nxt = q;
          rem_nxt = r;
        end
        default: res_nxt = d_in.res;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= d_in.vld;
    end
    if (adv) begin
      res_r <= res_nxt;
      rem_r <= rem_nxt;
      tr_r <= tr_nxt;
      st_r <= st_nxt;
    end
  end

  assign vld = vld_r;
  assign res = res_r;
  assign rem = rem_r;
  assign truth = tr_r;
  assign status = st_r;
endmodule

FILE: rtl/integer_alu_with_divide.sv
// Top level of the integer ALU with a pipelined divider chain.
// Usage:
// The input channel takes one word per cycle: in_operation, in_operand_a and
// in_operand_b, accepted when in_valid is high and in_stall is low.
// The result channel gives out_result_value, out_remainder_value, out_truth
// and out_status, taken when out_valid is high and out_stall is low.
// Every operation flows through the same pipeline: one decode stage, 32
// divider cells that each resolve one quotient bit, and one output stage.
// Throughput is one word per cycle while the receiver does not stall, set by the one-bit-per-cell chain.
// When the receiver stalls with a word waiting, every stage holds, empty or
// not, and in_stall is raised in the same cycle.
// Reset clears every valid bit, so the block comes up empty.
module integer_alu_with_divide (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [iad_pkg::OPW-1:0]        in_operation,
  input  logic signed [iad_pkg::DW-1:0]  in_operand_a,
  input  logic signed [iad_pkg::DW-1:0]  in_operand_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [iad_pkg::DW-1:0]  out_result_value,
  output logic signed [iad_pkg::DW-1:0]  out_remainder_value,
  output logic                           out_truth,
  output logic [1:0]                     out_status
);
`include "integer_alu_with_divide_macros.svh"
  iad_pkg::cell_t chain [iad_pkg::NCELL+1];
  logic adv;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  iad_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld(in_valid && adv),
    .op(in_operation), .a(in_operand_a), .b(in_operand_b), .d_out(chain[0])
  );

  for (genvar i = 0; i < iad_pkg::NCELL; i++) begin : g_cell
    iad_cell u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv), .d_in(chain[i]), .d_out(chain[i+1])
    );
  end

  iad_back u_back (
    .clk(clk), .rst_n(rst_n), .adv(adv), .d_in(chain[iad_pkg::NCELL]),
    .vld(out_valid), .res(out_result_value), .rem(out_remainder_value),
    .truth(out_truth), .status(out_status)
  );

  `IAD_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, out_valid,
    "input stalled while no output word waits")
  `IAD_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_result_value), "held output word changed")
  `IAD_ASSERT_IMP(a_dz_zero, clk, rst_n, out_valid && out_status == iad_pkg::ST_DIV_ZERO,
    out_result_value == '0 && out_remainder_value == '0 && !out_truth,
    "divide by zero gave nonzero results")
endmodule
